[hw/rtl/gff_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gff_pkg
// Shared types and constants of the grid flood fill block.
// ----------------------------------------------------------------------------
package gff_pkg;

   localparam int CMD_W   = 2;
   localparam int COORD_W = 5;
   localparam int CELL_W  = 8;
   localparam int COUNT_W = 11;
   localparam int CSR_W   = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [CELL_W-1:0] FILL_BYTE = 8'h46;

   localparam logic [CSR_W-1:0] GRID_WIDTH_RST  = 6'd32;
   localparam logic [CSR_W-1:0] GRID_HEIGHT_RST = 6'd32;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_FILL = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_TARGET,
      ST_POP,
      ST_POP_WAIT,
      ST_NBR,
      ST_NBR_CHK,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_req;
      logic set_oob;
      logic cell_wr;
      logic read_capture;
      logic target_capture;
      logic mark_start;
      logic pop;
      logic cur_capture;
      logic nbr_read;
      logic mark_nbr;
      logic dir_next;
      logic rsp_load;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    oob;
      logic    start_is_fill;
      logic    match;
      logic    nbr_ok;
      logic    dir_last;
      logic    stack_empty;
   } stat_type;

endpackage
`default_nettype wire

[hw/rtl/gff_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gff_req_if / gff_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface gff_req_if;
   logic                         valid;
   logic                         ready;
   logic [gff_pkg::CMD_W-1:0]    cmd;
   logic [gff_pkg::COORD_W-1:0]  col;
   logic [gff_pkg::COORD_W-1:0]  row;
   logic [gff_pkg::CELL_W-1:0]   cell_value;

   modport source (output valid, output cmd, output col, output row,
                   output cell_value, input ready);
   modport sink   (input valid, input cmd, input col, input row,
                   input cell_value, output ready);
endinterface

interface gff_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gff_pkg::CELL_W-1:0]   read_value;
   logic [gff_pkg::COUNT_W-1:0]  filled_count;
   logic                         status;

   modport source (output valid, output read_value, output filled_count,
                   output status, input ready);
   modport sink   (input valid, input read_value, input filled_count,
                   input status, output ready);
endinterface
`default_nettype wire

[hw/rtl/gff_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gff_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [AW-1:0]            rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/gff_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gff_datapath
// Grid and stack memories, size registers, cursor, counters, result regs.
// ----------------------------------------------------------------------------
module gff_datapath #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [gff_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gff_pkg::CSR_W-1:0]       csr_wdata,
   input  wire logic [gff_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [gff_pkg::COORD_W-1:0]     req_col,
   input  wire logic [gff_pkg::COORD_W-1:0]     req_row,
   input  wire logic [gff_pkg::CELL_W-1:0]      req_cell_value,
   input  wire gff_pkg::ctl_type                ctl,
   output gff_pkg::stat_type                    stat,
   output logic      [gff_pkg::CELL_W-1:0]      rsp_read_value,
   output logic      [gff_pkg::COUNT_W-1:0]     rsp_filled_count,
   output logic                                 rsp_status
);
   localparam int XW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int AW = XW + YW;
   localparam int SW = AW + 1;
   localparam int DEPTH = 2 ** AW;

   logic [gff_pkg::CSR_W-1:0]   gw_ff, gw_in, gh_ff, gh_in;
   gff_pkg::cmd_type            cmd_ff, cmd_in;
   logic                        oob_ff, oob_in;
   logic [XW-1:0]               x_ff, x_in, cur_x_ff, cur_x_in;
   logic [YW-1:0]               y_ff, y_in, cur_y_ff, cur_y_in;
   logic [gff_pkg::CELL_W-1:0]  val_ff, val_in, target_ff, target_in;
   gff_pkg::dir_type            dir_ff, dir_in;
   logic [SW-1:0]               sp_ff, sp_in, sp_m1;
   logic [gff_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [gff_pkg::CELL_W-1:0]  read_val_ff, read_val_in;
   logic                        status_ff, status_in;
   logic [gff_pkg::CELL_W-1:0]  out_val_ff, out_val_in;
   logic [gff_pkg::COUNT_W-1:0] out_count_ff, out_count_in;
   logic                        out_status_ff, out_status_in;

   logic                        col_oob, row_oob;
   logic [XW-1:0]               nbr_x;
   logic [YW-1:0]               nbr_y;
   logic                        nbr_ok;
   logic [AW-1:0]               req_addr, nbr_addr;

   logic                        cell_we;
   logic [AW-1:0]               cell_waddr, cell_raddr;
   logic [gff_pkg::CELL_W-1:0]  cell_wdata, cell_rdata;
   logic                        stk_we;
   logic [AW-1:0]               stk_wdata, stk_rdata;

   // size in use is the register capped at the grid maximum
   assign col_oob = ({1'b0, req_col} >= gw_ff) || (32'(req_col) >= MAX_COLS);
   assign row_oob = ({1'b0, req_row} >= gh_ff) || (32'(req_row) >= MAX_ROWS);

   assign req_addr = {y_ff, x_ff};
   assign nbr_addr = {nbr_y, nbr_x};
   assign sp_m1    = sp_ff - SW'(1);

   always_comb begin
      nbr_x  = cur_x_ff;
      nbr_y  = cur_y_ff;
      nbr_ok = 1'b0;
      case (dir_ff)
         gff_pkg::DIR_UP: begin
            nbr_y  = cur_y_ff - YW'(1);
            nbr_ok = (cur_y_ff != '0);
         end
         gff_pkg::DIR_LEFT: begin
            nbr_x  = cur_x_ff - XW'(1);
            nbr_ok = (cur_x_ff != '0);
         end
         gff_pkg::DIR_DOWN: begin
            nbr_y  = cur_y_ff + YW'(1);
            nbr_ok = ((32'(cur_y_ff) + 1) < 32'(gh_ff)) &&
                     ((32'(cur_y_ff) + 1) < MAX_ROWS);
         end
         gff_pkg::DIR_RIGHT: begin
            nbr_x  = cur_x_ff + XW'(1);
            nbr_ok = ((32'(cur_x_ff) + 1) < 32'(gw_ff)) &&
                     ((32'(cur_x_ff) + 1) < MAX_COLS);
         end
         default: begin
            nbr_ok = 1'b0;
         end
      endcase
   end

   // memory ports
   assign cell_we    = ctl.cell_wr | ctl.mark_start | ctl.mark_nbr;
   assign cell_waddr = ctl.mark_nbr ? nbr_addr : req_addr;
   assign cell_wdata = ctl.cell_wr ? val_ff : gff_pkg::FILL_BYTE;
   assign cell_raddr = ctl.nbr_read ? nbr_addr : req_addr;

   assign stk_we    = ctl.mark_start | ctl.mark_nbr;
   assign stk_wdata = ctl.mark_start ? req_addr : nbr_addr;

   gff_ram #(.WIDTH(gff_pkg::CELL_W), .DEPTH(DEPTH)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   gff_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff[AW-1:0]),
      .wr_data (stk_wdata),
      .rd_addr (sp_m1[AW-1:0]),
      .rd_data (stk_rdata)
   );

   always_comb begin
      gw_in        = gw_ff;
      gh_in        = gh_ff;
      cmd_in       = cmd_ff;
      oob_in       = oob_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      val_in       = val_ff;
      target_in    = target_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      dir_in       = dir_ff;
      sp_in        = sp_ff;
      count_in     = count_ff;
      read_val_in  = read_val_ff;
      status_in    = status_ff;
      out_val_in   = out_val_ff;
      out_count_in = out_count_ff;
      out_status_in = out_status_ff;

      if (csr_we) begin
         if (csr_index == gff_pkg::CSR_GRID_WIDTH) begin
            gw_in = csr_wdata;
         end else begin
            gh_in = csr_wdata;
         end
      end

      if (ctl.latch_req) begin
         cmd_in      = gff_pkg::cmd_type'(req_cmd);
         oob_in      = col_oob | row_oob;
         x_in        = XW'(req_col);
         y_in        = YW'(req_row);
         val_in      = req_cell_value;
         count_in    = '0;
         read_val_in = '0;
         status_in   = 1'b0;
      end
      if (ctl.set_oob) begin
         status_in = 1'b1;
      end
      if (ctl.read_capture) begin
         read_val_in = cell_rdata;
      end
      if (ctl.target_capture) begin
         target_in = cell_rdata;
      end
      if (ctl.mark_start) begin
         sp_in    = SW'(1);
         count_in = gff_pkg::COUNT_W'(1);
      end
      if (ctl.mark_nbr) begin
         sp_in    = sp_ff + SW'(1);
         count_in = count_ff + gff_pkg::COUNT_W'(1);
      end
      if (ctl.pop) begin
         sp_in = sp_m1;
      end
      if (ctl.cur_capture) begin
         cur_x_in = stk_rdata[XW-1:0];
         cur_y_in = stk_rdata[AW-1:XW];
         dir_in   = gff_pkg::DIR_UP;
      end else if (ctl.dir_next) begin
         dir_in = gff_pkg::dir_type'(dir_ff + 2'd1);
      end
      if (ctl.rsp_load) begin
         out_val_in    = read_val_ff;
         out_count_in  = count_ff;
         out_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff  <= gff_pkg::GRID_WIDTH_RST;
         gh_ff  <= gff_pkg::GRID_HEIGHT_RST;
         sp_ff  <= '0;
         dir_ff <= gff_pkg::DIR_UP;
      end else begin
         gw_ff  <= gw_in;
         gh_ff  <= gh_in;
         sp_ff  <= sp_in;
         dir_ff <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      oob_ff        <= oob_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      val_ff        <= val_in;
      target_ff     <= target_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      count_ff      <= count_in;
      read_val_ff   <= read_val_in;
      status_ff     <= status_in;
      out_val_ff    <= out_val_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
   end

   assign stat.cmd           = cmd_ff;
   assign stat.oob           = oob_ff;
   assign stat.start_is_fill = (cell_rdata == gff_pkg::FILL_BYTE);
   assign stat.match         = (cell_rdata == target_ff);
   assign stat.nbr_ok        = nbr_ok;
   assign stat.dir_last      = (dir_ff == gff_pkg::DIR_RIGHT);
   assign stat.stack_empty   = (sp_ff == '0);

   assign rsp_read_value   = out_val_ff;
   assign rsp_filled_count = out_count_ff;
   assign rsp_status       = out_status_ff;

endmodule
`default_nettype wire

[hw/rtl/gff_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gff_ctrl
// Sequencer for load, read and stack-driven fill; owns the response valid.
// ----------------------------------------------------------------------------
module gff_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire gff_pkg::stat_type stat,
   output gff_pkg::ctl_type       ctl
);
   gff_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gff_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;

      case (state_ff)
         gff_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch_req = 1'b1;
               state_in      = gff_pkg::ST_DECODE;
            end
         end
         gff_pkg::ST_DECODE: begin
            state_in = gff_pkg::ST_DONE;
            case (stat.cmd)
               gff_pkg::CMD_LOAD: begin
                  if (stat.oob) begin
                     ctl.set_oob = 1'b1;
                  end else begin
                     ctl.cell_wr = 1'b1;
                  end
               end
               gff_pkg::CMD_READ: begin
                  if (stat.oob) begin
                     ctl.set_oob = 1'b1;
                  end else begin
                     state_in = gff_pkg::ST_READ_WAIT;
                  end
               end
               gff_pkg::CMD_FILL: begin
                  if (stat.oob) begin
                     ctl.set_oob = 1'b1;
                  end else begin
                     state_in = gff_pkg::ST_TARGET;
                  end
               end
               default: begin
                  state_in = gff_pkg::ST_DONE;
               end
            endcase
         end
         gff_pkg::ST_READ_WAIT: begin
            ctl.read_capture = 1'b1;
            state_in         = gff_pkg::ST_DONE;
         end
         gff_pkg::ST_TARGET: begin
            // start already holds the fill byte: nothing to change
            ctl.target_capture = 1'b1;
            if (stat.start_is_fill) begin
               state_in = gff_pkg::ST_DONE;
            end else begin
               ctl.mark_start = 1'b1;
               state_in       = gff_pkg::ST_POP;
            end
         end
         gff_pkg::ST_POP: begin
            if (stat.stack_empty) begin
               state_in = gff_pkg::ST_DONE;
            end else begin
               ctl.pop  = 1'b1;
               state_in = gff_pkg::ST_POP_WAIT;
            end
         end
         gff_pkg::ST_POP_WAIT: begin
            ctl.cur_capture = 1'b1;
            state_in        = gff_pkg::ST_NBR;
         end
         gff_pkg::ST_NBR: begin
            if (stat.nbr_ok) begin
               ctl.nbr_read = 1'b1;
               state_in     = gff_pkg::ST_NBR_CHK;
            end else if (stat.dir_last) begin
               state_in = gff_pkg::ST_POP;
            end else begin
               ctl.dir_next = 1'b1;
            end
         end
         gff_pkg::ST_NBR_CHK: begin
            // mark on push so no cell enters the stack twice
            ctl.mark_nbr = stat.match;
            if (stat.dir_last) begin
               state_in = gff_pkg::ST_POP;
            end else begin
               ctl.dir_next = 1'b1;
               state_in     = gff_pkg::ST_NBR;
            end
         end
         gff_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = gff_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gff_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = ctl.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[hw/rtl/grid_flood_fill.sv]
`default_nettype none
// Fill pops each cell off a stack and reads its in-grid neighbors one at a time,
// skipping off-grid ones; a fill whose start holds 'F' changes nothing.
// The grid RAM has a single read port, so each neighbor probe is its own read.
// One item in flight; the next beat is taken while a response waits.
// Synchronous reset clears control, sets the size to 32x32; grid is undefined.
// ----------------------------------------------------------------------------
// grid_flood_fill
// Byte grid with load, read and four-connected flood fill commands.
// ----------------------------------------------------------------------------
module grid_flood_fill #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gff_req_if.sink                             req_ch,
   gff_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [gff_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gff_pkg::CSR_W-1:0]      csr_wdata
);
   gff_pkg::ctl_type  ctl;
   gff_pkg::stat_type stat;

   gff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   gff_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cmd          (req_ch.cmd),
      .req_col          (req_ch.col),
      .req_row          (req_ch.row),
      .req_cell_value   (req_ch.cell_value),
      .ctl              (ctl),
      .stat             (stat),
      .rsp_read_value   (rsp_ch.read_value),
      .rsp_filled_count (rsp_ch.filled_count),
      .rsp_status       (rsp_ch.status)
   );

   a_push_matches: assert property (@(posedge clock) disable iff (reset)
      ctl.mark_nbr |-> stat.match)
      else $error("neighbor marked without matching target");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> !stat.stack_empty)
      else $error("pop from empty stack");

   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status) |->
         (rsp_ch.read_value == '0 && rsp_ch.filled_count == '0))
      else $error("error response carries nonzero payload");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |=> rsp_ch.valid)
      else $error("loaded response not presented");

endmodule
`default_nettype wire

[bench/grid_flood_fill_check.sv]
// ----------------------------------------------------------------------------
// grid_flood_fill_check
// Watches the request, response and register ports of the flood fill block.
// Keeps its own copy of the grid and size registers, works out the response
// of every accepted request beat, and compares each response beat field by
// field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module grid_flood_fill_check #(
   parameter int MAX_COLS = 32,
   parameter int MAX_ROWS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   gff_req_if                                   req_ch,
   gff_rsp_if                                   rsp_ch,
   input  wire logic                            csr_we,
   input  wire gff_pkg::csr_idx_type            csr_index,
   input  wire logic [gff_pkg::CSR_W-1:0]       csr_wdata,
   output int                                   fail_count,
   output int                                   pending_count
);
   import gff_pkg::*;

   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int IDX_W = $clog2(CELLS);

   typedef struct packed {
      logic [CELL_W-1:0]  read_value;
      logic [COUNT_W-1:0] filled_count;
      logic               status;
   } grid_rsp_type;

   logic [CELL_W-1:0] grid_model [CELLS];
   logic [IDX_W-1:0]  fill_stack [CELLS];
   int                stack_top;
   int                changed_cells;
   logic [CSR_W-1:0]  width_reg = GRID_WIDTH_RST;
   logic [CSR_W-1:0]  height_reg = GRID_HEIGHT_RST;
   grid_rsp_type      awaited_rsp [$];
   int                fail_total = 0;
   int                awaited_total = 0;

   assign fail_count    = fail_total;
   assign pending_count = awaited_total;

   // Rewrite a matching cell at push time so it never enters the stack twice.
   function automatic void claim_cell(int cell_idx, logic [CELL_W-1:0] target);
      if (grid_model[cell_idx] == target) begin
         grid_model[cell_idx] = FILL_BYTE;
         changed_cells++;
         fill_stack[stack_top] = IDX_W'(cell_idx);
         stack_top++;
      end
   endfunction

   function automatic logic [COUNT_W-1:0] flood_count(int x0, int y0, int w, int h);
      logic [CELL_W-1:0] target;
      int                cell_idx;
      int                x;
      int                y;
      target        = grid_model[y0 * MAX_COLS + x0];
      stack_top     = 0;
      changed_cells = 0;
      if (target != FILL_BYTE) begin
         claim_cell(y0 * MAX_COLS + x0, target);
         while (stack_top > 0) begin
            stack_top--;
            cell_idx = int'(fill_stack[stack_top]);
            x        = cell_idx % MAX_COLS;
            y        = cell_idx / MAX_COLS;
            if (y > 0)
               claim_cell(cell_idx - MAX_COLS, target);
            if (x > 0)
               claim_cell(cell_idx - 1, target);
            if (y + 1 < h)
               claim_cell(cell_idx + MAX_COLS, target);
            if (x + 1 < w)
               claim_cell(cell_idx + 1, target);
         end
      end
      return COUNT_W'(changed_cells);
   endfunction

   function automatic grid_rsp_type grid_response(logic [CMD_W-1:0] op,
                                                  logic [COORD_W-1:0] col,
                                                  logic [COORD_W-1:0] row,
                                                  logic [CELL_W-1:0] value);
      grid_rsp_type rsp;
      int           w;
      int           h;
      int           cell_idx;
      rsp      = '0;
      w        = (int'(width_reg) > MAX_COLS) ? MAX_COLS : int'(width_reg);
      h        = (int'(height_reg) > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
      cell_idx = int'(row) * MAX_COLS + int'(col);
      // unknown opcodes answer all zero and touch nothing
      if (op == CMD_LOAD || op == CMD_FILL || op == CMD_READ) begin
         if (int'(col) >= w || int'(row) >= h || cell_idx >= CELLS) begin
            rsp.status = 1'b1;
         end else begin
            case (op)
               CMD_LOAD: grid_model[cell_idx] = value;
               CMD_READ: rsp.read_value = grid_model[cell_idx];
               default:  rsp.filled_count = flood_count(int'(col), int'(row), w, h);
            endcase
         end
      end
      return rsp;
   endfunction

   always @(posedge clock) begin : monitor
      grid_rsp_type seen;
      grid_rsp_type want;
      if (reset) begin
         width_reg  = GRID_WIDTH_RST;
         height_reg = GRID_HEIGHT_RST;
         awaited_rsp.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.read_value   = rsp_ch.read_value;
            seen.filled_count = rsp_ch.filled_count;
            seen.status       = rsp_ch.status;
            if (awaited_rsp.size() == 0) begin
               $display({"%0t: response beat expected none, ",
                         "got read_value %0h filled_count %0d status %0b"},
                        $time, seen.read_value, seen.filled_count, seen.status);
               fail_total++;
            end else begin
               want = awaited_rsp.pop_front();
               if (seen.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %0h, got %0h",
                           $time, want.read_value, seen.read_value);
                  fail_total++;
               end
               if (seen.filled_count !== want.filled_count) begin
                  $display("%0t: filled_count expected %0d, got %0d",
                           $time, want.filled_count, seen.filled_count);
                  fail_total++;
               end
               if (seen.status !== want.status) begin
                  $display("%0t: status expected %0b, got %0b",
                           $time, want.status, seen.status);
                  fail_total++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_WIDTH:  width_reg  = csr_wdata;
               CSR_GRID_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            awaited_rsp.push_back(grid_response(req_ch.cmd, req_ch.col, req_ch.row,
                                                req_ch.cell_value));
      end
      awaited_total = awaited_rsp.size();
   end

endmodule

[bench/grid_flood_fill_test.sv]
// ----------------------------------------------------------------------------
// grid_flood_fill_test
// Drives load, read and fill beats into the flood fill block over several
// grid sizes, including zero and oversized ones. Each size starts with every
// cell in use loaded, so no fill or read touches an unloaded cell. Sender gaps
// and receiver stalls vary by phase, one phase holds the response side off
// long enough to back up the request side, and a separate checker scores
// every response.
// ----------------------------------------------------------------------------
module grid_flood_fill_test;
   import gff_pkg::*;

   localparam int GRID_COLS      = 32;
   localparam int GRID_ROWS      = 32;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   csr_idx_type       csr_index;
   logic [CSR_W-1:0]  csr_wdata;
   int                mismatch_total;
   int                awaiting;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                hold_asks = 0;
   int                span_cols = GRID_COLS;
   int                span_rows = GRID_ROWS;
   int                quiet_cycles = 0;
   bit                loaded [GRID_COLS*GRID_ROWS];

   gff_req_if req_ch ();
   gff_rsp_if rsp_ch ();

   always #10 clock = ~clock;

   grid_flood_fill #(
      .MAX_COLS(GRID_COLS),
      .MAX_ROWS(GRID_ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   grid_flood_fill_check #(
      .MAX_COLS(GRID_COLS),
      .MAX_ROWS(GRID_ROWS)
   ) fill_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (mismatch_total),
      .pending_count(awaiting)
   );

   // Response side: random stalls, plus a long hold-off on request.
   initial begin : rsp_sink
      int hold_left;
      int hold_seen;
      hold_left    = 0;
      hold_seen    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("grid_flood_fill: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(logic [CMD_W-1:0] op, logic [COORD_W-1:0] col,
                            logic [COORD_W-1:0] row, logic [CELL_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= op;
      req_ch.col        <= col;
      req_ch.row        <= row;
      req_ch.cell_value <= value;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (awaiting != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure_grid(int w, int h);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= CSR_W'(w);
      @(negedge clock);
      csr_index <= CSR_GRID_HEIGHT;
      csr_wdata <= CSR_W'(h);
      @(negedge clock);
      csr_we    <= 1'b0;
      span_cols = (w > GRID_COLS) ? GRID_COLS : w;
      span_rows = (h > GRID_ROWS) ? GRID_ROWS : h;
   endtask

   // Favor two recurring bytes so loads build connected regions to fill.
   function automatic logic [CELL_W-1:0] pick_value();
      int pick;
      pick = $urandom_range(9);
      if (pick < 3)
         return 8'h3C;
      else if (pick < 5)
         return 8'hC3;
      else if (pick == 5)
         return FILL_BYTE;
      return CELL_W'($urandom_range(255));
   endfunction

   task automatic load_region();
      int r;
      int c;
      for (r = 0; r < span_rows; r++)
         for (c = 0; c < span_cols; c++)
            if (!loaded[r*GRID_COLS + c]) begin
               send_beat(CMD_LOAD, COORD_W'(c), COORD_W'(r), pick_value());
               loaded[r*GRID_COLS + c] = 1'b1;
            end
   endtask

   task automatic random_item();
      int                 pick;
      logic [CMD_W-1:0]   op;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [CELL_W-1:0]  value;
      pick  = $urandom_range(99);
      value = pick_value();
      col   = COORD_W'($urandom_range(span_cols - 1));
      row   = COORD_W'($urandom_range(span_rows - 1));
      if (pick < 40) begin
         op = CMD_LOAD;
      end else if (pick < 65) begin
         op = CMD_FILL;
      end else if (pick < 85) begin
         op = CMD_READ;
      end else if (pick < 95) begin
         // push the coordinate past the used grid on one axis
         op = CMD_W'($urandom_range(2));
         if (span_cols < GRID_COLS && (span_rows == GRID_ROWS || $urandom_range(1) == 1)) begin
            col = COORD_W'($urandom_range(GRID_COLS - 1, span_cols));
            row = COORD_W'($urandom_range(GRID_ROWS - 1));
         end else if (span_rows < GRID_ROWS) begin
            row = COORD_W'($urandom_range(GRID_ROWS - 1, span_rows));
            col = COORD_W'($urandom_range(GRID_COLS - 1));
         end
      end else begin
         op  = CMD_UNUSED;
         col = COORD_W'($urandom_range(GRID_COLS - 1));
         row = COORD_W'($urandom_range(GRID_ROWS - 1));
         value = CELL_W'($urandom_range(255));
      end
      if (op == CMD_LOAD && int'(col) < span_cols && int'(row) < span_rows)
         loaded[int'(row)*GRID_COLS + int'(col)] = 1'b1;
      send_beat(op, col, row, value);
   endtask

   task automatic run_phase(int w, int h, int send_pct, int stall_pct, int items,
                            bit backpressure);
      drain();
      configure_grid(w, h);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      load_region();
      if (backpressure)
         hold_asks++;
      repeat (items) random_item();
   endtask

   initial begin : stimulus
      int r;
      int c;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_LOAD;
      req_ch.col        = '0;
      req_ch.row        = '0;
      req_ch.cell_value = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_GRID_WIDTH;
      csr_wdata         = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // 3x3 grid: a U of zeros, a right column of 0xFF and one lone 0xFF
      drain();
      configure_grid(3, 3);
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++) begin
            send_beat(CMD_LOAD, COORD_W'(c), COORD_W'(r),
                      (c == 2 || (c == 0 && r == 1)) ? 8'hFF : 8'h00);
            loaded[r*GRID_COLS + c] = 1'b1;
         end
      send_beat(CMD_READ, COORD_W'(2), COORD_W'(2), 8'h00);
      send_beat(CMD_FILL, COORD_W'(0), COORD_W'(0), 8'h00);
      // start already holds the fill byte
      send_beat(CMD_FILL, COORD_W'(0), COORD_W'(0), 8'h00);
      send_beat(CMD_READ, COORD_W'(1), COORD_W'(1), 8'h00);
      send_beat(CMD_FILL, COORD_W'(2), COORD_W'(0), 8'h00);
      send_beat(CMD_FILL, COORD_W'(0), COORD_W'(1), 8'h00);    // isolated cell
      send_beat(CMD_LOAD, COORD_W'(3), COORD_W'(0), 8'hA5);    // column just past the edge
      send_beat(CMD_READ, COORD_W'(0), COORD_W'(31), 8'h00);
      send_beat(CMD_FILL, COORD_W'(31), COORD_W'(31), 8'hFF);
      send_beat(CMD_UNUSED, COORD_W'(0), COORD_W'(0), 8'hFF);
      send_beat(CMD_UNUSED, COORD_W'(31), COORD_W'(31), 8'h00);

      // zero height, then zero width: everything lies outside
      drain();
      configure_grid(4, 0);
      send_beat(CMD_READ, COORD_W'(0), COORD_W'(0), 8'h00);
      drain();
      configure_grid(0, 3);
      send_beat(CMD_FILL, COORD_W'(0), COORD_W'(0), 8'h00);
      send_beat(CMD_LOAD, COORD_W'(0), COORD_W'(0), 8'h5A);

      run_phase(63, 1, 0, 0, 10, 1'b0);
      run_phase(1, 12, 52, 0, 10, 1'b0);
      run_phase(4, 4, 0, 52, 10, 1'b1);
      run_phase(12, 2, 38, 38, 10, 1'b0);
      run_phase(6, 6, 0, 0, 10, 1'b0);
      drain();

      if (mismatch_total == 0 && awaiting == 0)
         $display("grid_flood_fill: match");
      else
         $display("grid_flood_fill: mismatch");
      $finish;
   end

endmodule
